>>> rtl/core/lge_pkg.sv
// lge_pkg: shared types and constants of the life generation engine.
// Used by lge_lane, lge_row_update and life_generation_engine; no dependencies.
package lge_pkg;

	localparam int GRID_ROWS_DEF = 64;
	localparam int GRID_COLS_DEF = 64;
	localparam int ROW_BITS_W    = 64;
	localparam int CFG_W         = 7;
	localparam int CFG_RESET     = 64;

	localparam logic [1:0] FUNC_WR  = 2'd0;
	localparam logic [1:0] FUNC_RD  = 2'd1;
	localparam logic [1:0] FUNC_ADV = 2'd2;

	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	// eight neighbors of one cell, old generation
	typedef struct packed {
		logic above_l;
		logic above_c;
		logic above_r;
		logic mid_l;
		logic mid_r;
		logic below_l;
		logic below_c;
		logic below_r;
	} nbr_t;

endpackage

>>> rtl/core/lge_ram.sv
// lge_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lge_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/lge_lane.sv
// lge_lane: next state of one cell under the Conway rule; an inactive cell keeps its state.
// Depends on lge_pkg.
module lge_lane (
	input  lge_pkg::nbr_t nbr,
	input  logic          alive,
	input  logic          active,
	output logic          next_cell
);

	logic [3:0] count;
	logic       rule;

	assign count = 4'($countones(nbr));
	assign rule  = alive ? (count == 4'd2 || count == 4'd3) : (count == 4'd3);
	assign next_cell = active ? rule : alive;

endmodule

>>> rtl/core/lge_row_update.sv
// lge_row_update: one lane per column, wrap at the active column edge, row merge.
// Depends on lge_pkg and lge_lane.
module lge_row_update #(
	parameter int GRID_COLS = lge_pkg::GRID_COLS_DEF,
	localparam int COL_AW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1
) (
	input  logic [GRID_COLS-1:0] above,
	input  logic [GRID_COLS-1:0] cur,
	input  logic [GRID_COLS-1:0] below,
	input  logic [COL_AW-1:0]    last_col,
	output logic [GRID_COLS-1:0] next_row
);

	logic wrap_above, wrap_cur, wrap_below;

	assign wrap_above = above[last_col];
	assign wrap_cur   = cur[last_col];
	assign wrap_below = below[last_col];

	for (genvar x = 0; x < GRID_COLS; x++) begin : g_lane
		lge_pkg::nbr_t nbr;
		logic          active;

		assign active  = (COL_AW'(x) <= last_col);

		if (x == 0) begin : g_left_wrap
			assign nbr.above_l = wrap_above;
			assign nbr.mid_l   = wrap_cur;
			assign nbr.below_l = wrap_below;
		end else begin : g_left
			assign nbr.above_l = above[x-1];
			assign nbr.mid_l   = cur[x-1];
			assign nbr.below_l = below[x-1];
		end

		if (x == GRID_COLS - 1) begin : g_right_wrap
			assign nbr.above_r = above[0];
			assign nbr.mid_r   = cur[0];
			assign nbr.below_r = below[0];
		end else begin : g_right
			logic is_last;

			assign is_last     = (COL_AW'(x) == last_col);
			assign nbr.above_r = is_last ? above[0] : above[x+1];
			assign nbr.mid_r   = is_last ? cur[0]   : cur[x+1];
			assign nbr.below_r = is_last ? below[0] : below[x+1];
		end

		assign nbr.above_c = above[x];
		assign nbr.below_c = below[x];

		lge_lane u_lane (
			.nbr       (nbr),
			.alive     (cur[x]),
			.active    (active),
			.next_cell (next_row[x])
		);
	end

endmodule

>>> rtl/core/life_generation_engine.sv
// life_generation_engine: toroidal Game of Life grid with row write, row read, advance.
// Depends on lge_pkg, lge_ram and lge_row_update.
// Write and unused code finish from idle; read passes ST_RD; advance ST_A0, ST_A1, then ST_AS per row.
// Throughput: one item at a time; advance is bound by one RAM read and write per row.
// done pulses for one cycle with row_bits_out; the receiver cannot stall.
// Reset: grid reads as all dead through per-row valid bits, no clearing pass; config 64/64.
module life_generation_engine #(
	parameter int GRID_ROWS = lge_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLS = lge_pkg::GRID_COLS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     func,
	input  logic [5:0]                     row_index,
	input  logic [lge_pkg::ROW_BITS_W-1:0] row_bits_in,
	output logic                           done,
	output logic [lge_pkg::ROW_BITS_W-1:0] row_bits_out,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [lge_pkg::CFG_W-1:0]      cfg_data
);

	// row count register cannot exceed 127, nor row_index 63
	localparam int RAM_DEPTH = (GRID_ROWS < 128) ? GRID_ROWS : 128;
	localparam int ROW_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
	localparam int COL_AW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_A0,
		ST_A1,
		ST_AS
	} state_t;

	state_t state_q;

	logic [lge_pkg::CFG_W-1:0] rows_q, cols_q;
	logic [ROW_AW-1:0]         last_row, last_row_q, wr_row_q;
	logic [COL_AW-1:0]         last_col, last_col_q;
	logic [31:0]               rows_ext, cols_ext, idx_ext;
	logic [ROW_AW-1:0]         idx_addr;
	logic                      idx_ok;
	logic [ROW_AW:0]           rd_next;

	logic [GRID_COLS-1:0] prev_q, cur_q, first_q;
	logic [GRID_COLS-1:0] ram_rdata, rd_row, below, next_row;
	logic [RAM_DEPTH-1:0] valid_q;
	logic                 rd_valid_q;

	logic                 ram_we;
	logic [ROW_AW-1:0]    ram_waddr, ram_raddr;
	logic [GRID_COLS-1:0] ram_wdata;
	logic                 accept;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= lge_pkg::CFG_W'(lge_pkg::CFG_RESET);
			cols_q <= lge_pkg::CFG_W'(lge_pkg::CFG_RESET);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == lge_pkg::CFG_ROWS) begin
				rows_q <= cfg_data;
			end else begin
				cols_q <= cfg_data;
			end
		end
	end

	// saturate active area
	assign rows_ext = 32'(rows_q);
	assign cols_ext = 32'(cols_q);

	always_comb begin
		if (rows_ext < 32'd3) begin
			last_row = ROW_AW'(2);
		end else if (rows_ext > 32'(RAM_DEPTH)) begin
			last_row = ROW_AW'(RAM_DEPTH - 1);
		end else begin
			last_row = ROW_AW'(rows_ext - 32'd1);
		end
		if (cols_ext < 32'd3) begin
			last_col = COL_AW'(2);
		end else if (cols_ext > 32'(GRID_COLS)) begin
			last_col = COL_AW'(GRID_COLS - 1);
		end else begin
			last_col = COL_AW'(cols_ext - 32'd1);
		end
	end

	assign idx_ext  = 32'(row_index);
	assign idx_addr = idx_ext[ROW_AW-1:0];
	assign idx_ok   = (idx_ext < 32'(GRID_ROWS));

	assign rd_row  = rd_valid_q ? ram_rdata : '0;
	assign below   = (wr_row_q == last_row_q) ? first_q : rd_row;
	assign rd_next = {1'b0, wr_row_q} + (ROW_AW+1)'(2);

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_addr;
		ram_wdata = row_bits_in[GRID_COLS-1:0];
		ram_raddr = idx_addr;
		case (state_q)
			ST_IDLE: begin
				ram_we = accept && (func == lge_pkg::FUNC_WR) && idx_ok;
				if (func == lge_pkg::FUNC_ADV) begin
					ram_raddr = last_row;
				end
			end
			ST_A0: begin
				ram_raddr = '0;
			end
			ST_A1: begin
				ram_raddr = ROW_AW'(1);
			end
			ST_AS: begin
				ram_we    = 1'b1;
				ram_waddr = wr_row_q;
				ram_wdata = next_row;
				ram_raddr = (rd_next > {1'b0, last_row_q}) ? '0 : rd_next[ROW_AW-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	lge_ram #(
		.WIDTH (GRID_COLS),
		.DEPTH (RAM_DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lge_row_update #(
		.GRID_COLS (GRID_COLS)
	) u_row_update (
		.above    (prev_q),
		.cur      (cur_q),
		.below    (below),
		.last_col (last_col_q),
		.next_row (next_row)
	);

	// row valid bits: unwritten rows read as dead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			rd_valid_q <= valid_q[ram_raddr];
		end
	end

	// advance window: old previous, current and first rows
	always_ff @(posedge clk) begin
		case (state_q)
			ST_A0: begin
				prev_q <= rd_row;
			end
			ST_A1: begin
				cur_q   <= rd_row;
				first_q <= rd_row;
			end
			ST_AS: begin
				prev_q <= cur_q;
				cur_q  <= below;
			end
			default: begin
				prev_q <= prev_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done         <= 1'b0;
			row_bits_out <= '0;
			wr_row_q     <= '0;
			last_row_q   <= '0;
			last_col_q   <= '0;
		end else begin
			done         <= 1'b0;
			row_bits_out <= '0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_row_q <= last_row;
						last_col_q <= last_col;
						if (func == lge_pkg::FUNC_RD && idx_ok) begin
							state_q <= ST_RD;
						end else if (func == lge_pkg::FUNC_ADV) begin
							state_q <= ST_A0;
						end else begin
							done <= 1'b1;
						end
					end
				end
				ST_RD: begin
					done         <= 1'b1;
					row_bits_out <= lge_pkg::ROW_BITS_W'(rd_row);
					state_q      <= ST_IDLE;
				end
				ST_A0: begin
					state_q <= ST_A1;
				end
				ST_A1: begin
					wr_row_q <= '0;
					state_q  <= ST_AS;
				end
				ST_AS: begin
					if (wr_row_q == last_row_q) begin
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						wr_row_q <= wr_row_q + ROW_AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == lge_pkg::FUNC_WR |=> done && row_bits_out == '0)
		else $error("write transfer without zero result");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_AS |-> wr_row_q <= last_row_q)
		else $error("advance row past active area");

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD || state_q == ST_A0 || state_q == ST_A1 |-> !ram_we)
		else $error("grid write outside write or sweep");

endmodule

>>> test/life_checker.sv
// life_checker: watches the command, result and register channels of life_generation_engine,
// predicts every result from its own grid copy and compares. Depends on lge_pkg only.
// Hands its mismatch count and the number of outstanding results to tb_top.
module life_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  func,
	input  logic [5:0]  row_index,
	input  logic [63:0] row_bits_in,
	input  logic        done,
	input  logic [63:0] row_bits_out,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	output int          fail_count,
	output int          pending
);
	import lge_pkg::*;

	logic [63:0] cells [64];
	logic [6:0]  rows_reg;
	logic [6:0]  cols_reg;
	logic [63:0] expected_rows [$];

	function automatic int clamp_span(logic [6:0] v, int top);
		if (v < 3)
			return 3;
		if (v > top)
			return top;
		return int'(v);
	endfunction

	// next generation of the active columns of one row; inactive bits are kept
	function automatic logic [63:0] evolve_row(logic [63:0] above, logic [63:0] cur,
			logic [63:0] below, int ncols);
		logic [63:0] nxt;
		int left;
		int right;
		int count;
		nxt = cur;
		for (int x = 0; x < ncols; x++) begin
			left  = (x == 0) ? ncols - 1 : x - 1;
			right = (x == ncols - 1) ? 0 : x + 1;
			count = above[left] + above[x] + above[right] + cur[left] + cur[right]
				+ below[left] + below[x] + below[right];
			nxt[x] = cur[x] ? (count == 2 || count == 3) : (count == 3);
		end
		return nxt;
	endfunction

	task automatic advance_generation();
		int          nrows;
		int          ncols;
		logic [63:0] first_old;
		logic [63:0] prev_old;
		logic [63:0] cur;
		logic [63:0] below;
		nrows     = clamp_span(rows_reg, 64);
		ncols     = clamp_span(cols_reg, 64);
		first_old = cells[0];
		prev_old  = cells[nrows-1];
		for (int r = 0; r < nrows; r++) begin
			cur      = cells[r];
			below    = (r == nrows - 1) ? first_old : cells[r+1];
			cells[r] = evolve_row(prev_old, cur, below, ncols);
			prev_old = cur;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [63:0] want;
		logic [63:0] oldest;
		if (!arst_n) begin
			foreach (cells[i])
				cells[i] = '0;
			rows_reg = 7'(CFG_RESET);
			cols_reg = 7'(CFG_RESET);
			expected_rows.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (done) begin
				if (expected_rows.size() == 0) begin
					$error("row_bits_out: expected no result, got %h", row_bits_out);
					fail_count++;
				end else begin
					oldest = expected_rows.pop_front();
					if (row_bits_out !== oldest) begin
						$error("row_bits_out: expected %h, got %h", oldest, row_bits_out);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ROWS: rows_reg = cfg_data;
					CFG_COLS: cols_reg = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				want = '0;
				case (func)
					FUNC_WR: cells[row_index] = row_bits_in;
					FUNC_RD: want = cells[row_index];
					FUNC_ADV: advance_generation();
					default: ;
				endcase
				expected_rows.push_back(want);
			end
			pending = expected_rows.size();
		end
	end

endmodule

>>> test/tb_top.sv
// tb_top: stimulus and verdict for life_generation_engine; directed items, then
// register phases of pattern loads, advances, reads and noise. Depends on lge_pkg,
// life_generation_engine and life_checker, which does all prediction and comparison.
module tb_top;
	import lge_pkg::*;

	localparam logic [1:0] FUNC_NONE   = 2'd3;
	localparam int         ITEM_TARGET = 1550;
	localparam int         CYCLE_LIMIT = 1000000;
	localparam int         TAIL_CYCLES = 80;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  func;
	logic [5:0]  row_index;
	logic [63:0] row_bits_in;
	logic        done;
	logic [63:0] row_bits_out;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [6:0]  cfg_data;
	int          fail_count;
	int          pending;
	int          items_sent;
	int          cycle_count = 0;
	bit          gapless;

	int fixed_rows [7] = '{3, 64, 0, 127, 3, 64, 5};
	int fixed_cols [7] = '{3, 64, 127, 0, 64, 3, 2};

	life_generation_engine u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.row_index   (row_index),
		.row_bits_in (row_bits_in),
		.done        (done),
		.row_bits_out(row_bits_out),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	life_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.row_index   (row_index),
		.row_bits_in (row_bits_in),
		.done        (done),
		.row_bits_out(row_bits_out),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [63:0] random_row(int density);
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		c = {$urandom, $urandom};
		case (density)
			0: return a & b & c;
			1: return a & b;
			2: return a;
			default: return a | b;
		endcase
	endfunction

	function automatic int clamp_rows(int v);
		return (v < 3) ? 3 : (v > 64) ? 64 : v;
	endfunction

	// called and returning at a falling edge; start stays high for back-to-back transfers
	task automatic issue(logic [1:0] f, logic [5:0] r, logic [63:0] bits);
		int gap;
		if ($urandom_range(0, 31) == 0)
			gapless = !gapless;
		gap = gapless ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start       = 1'b1;
		func        = f;
		row_index   = r;
		row_bits_in = bits;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic drain();
		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_register(logic idx, logic [6:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		int phase;
		int rv;
		int cv;
		int eff_rows;
		int quota;
		int dens;
		start       = 1'b0;
		func        = FUNC_WR;
		row_index   = '0;
		row_bits_in = '0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_ROWS;
		cfg_data    = '0;
		items_sent  = 0;
		gapless     = 1'b0;
		arst_n      = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset state, extremes of rows and bits, unused code, two advances on 64x64
		issue(FUNC_RD, 6'd0, '0);
		issue(FUNC_RD, 6'd63, '1);
		issue(FUNC_WR, 6'd0, '1);
		issue(FUNC_WR, 6'd63, '1);
		issue(FUNC_WR, 6'd5, 64'haaaa_aaaa_aaaa_aaaa);
		issue(FUNC_WR, 6'd6, 64'h5555_5555_5555_5555);
		issue(FUNC_WR, 6'd20, 64'h0000_0000_0000_0007);
		issue(FUNC_RD, 6'd0, '0);
		issue(FUNC_RD, 6'd63, '0);
		issue(FUNC_RD, 6'd5, '0);
		issue(FUNC_NONE, 6'd63, '1);
		issue(FUNC_RD, 6'd6, '0);
		issue(FUNC_ADV, 6'd0, '0);
		issue(FUNC_RD, 6'd0, '0);
		issue(FUNC_RD, 6'd1, '0);
		issue(FUNC_RD, 6'd62, '0);
		issue(FUNC_RD, 6'd63, '0);
		issue(FUNC_RD, 6'd5, '0);
		issue(FUNC_RD, 6'd19, '0);
		issue(FUNC_RD, 6'd21, '0);
		issue(FUNC_ADV, 6'd63, '1);
		issue(FUNC_RD, 6'd20, '0);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			drain();
			if (phase < 7) begin
				rv = fixed_rows[phase];
				cv = fixed_cols[phase];
			end else begin
				rv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(3, 64);
				cv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(3, 64);
			end
			if ($urandom_range(0, 1)) begin
				write_register(CFG_ROWS, 7'(rv));
				write_register(CFG_COLS, 7'(cv));
			end else begin
				write_register(CFG_COLS, 7'(cv));
				write_register(CFG_ROWS, 7'(rv));
			end
			eff_rows = clamp_rows(rv);
			quota    = items_sent + $urandom_range(40, 140);
			while (items_sent < quota) begin
				if ($urandom_range(0, 3) != 0) begin
					// load the active rows, then run a few generations with reads between
					dens = $urandom_range(0, 3);
					for (int r = 0; r < eff_rows; r++)
						issue(FUNC_WR, 6'(r), random_row(dens));
					repeat ($urandom_range(1, 6)) begin
						issue(FUNC_ADV, 6'($urandom_range(0, 63)), random_row(3));
						repeat ($urandom_range(0, 3))
							issue(FUNC_RD, ($urandom_range(0, 4) == 0) ?
								6'($urandom_range(0, 63)) : 6'($urandom_range(0, eff_rows - 1)),
								random_row(3));
					end
				end else begin
					repeat ($urandom_range(1, 8))
						issue(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
							random_row($urandom_range(0, 3)));
					if ($urandom_range(0, 9) == 0)
						drain();
				end
			end
			phase++;
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> files.f
rtl/core/lge_pkg.sv
rtl/core/lge_ram.sv
rtl/core/lge_lane.sv
rtl/core/lge_row_update.sv
rtl/core/life_generation_engine.sv
test/life_checker.sv
test/tb_top.sv
